// ----- rtl/http_request_header_parser_macros.svh -----
// Assertion macros for the HTTP request header parser.
`ifndef HTTP_REQUEST_HEADER_PARSER_MACROS_SVH
`define HTTP_REQUEST_HEADER_PARSER_MACROS_SVH
// Assert that a condition implies a consequence in the same cycle.
`define HRP_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle.
`define HRP_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// ----- rtl/hrp_pkg.sv -----
// Package: types, codes and character classes of the HTTP request parser.
`default_nettype none
package hrp_pkg;
  typedef enum logic [4:0] {
    S_METHOD_START, S_METHOD, S_URI, S_H, S_T1, S_T2, S_P, S_SLASH,
    S_MAJ_START, S_MAJ, S_MIN_START, S_NL1, S_LINE_START, S_LWS,
    S_HNAME, S_SP_BEFORE_VALUE, S_HVALUE, S_NL2, S_NL3
  } state_t;

  localparam logic [1:0] ST_BUSY = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_SYNTAX = 2'd2;
  localparam logic [1:0] ST_BAD_URI = 2'd3;

  localparam logic [2:0] FK_NONE = 3'd0;
  localparam logic [2:0] FK_METHOD = 3'd1;
  localparam logic [2:0] FK_PATH = 3'd2;
  localparam logic [2:0] FK_QUERY = 3'd3;
  localparam logic [2:0] FK_HNAME = 3'd4;
  localparam logic [2:0] FK_HVALUE = 3'd5;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // One classified beat passed from the front end to the back end.
  typedef struct packed {
    logic       restart;
    logic [7:0] data;
    logic       is_ctl;
    logic       is_token;
    logic       is_dec;
    logic       is_hex;
    logic [3:0] hex;
  } beat_t;

  function automatic logic f_is_ctl(input logic [7:0] c);
    return (c <= 8'd31) || (c == 8'd127);
  endfunction

  function automatic logic f_is_tspecial(input logic [7:0] c);
    case (c)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "?",
      "=", "{", "}", " ", 8'h09: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction
endpackage
`default_nettype wire

// ----- rtl/hrp_front.sv -----
// Front end: accept beats, classify characters, feed a two-entry queue.
`default_nettype none
module hrp_front import hrp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic       in_operation,
  input  wire logic [7:0] in_data_byte,
  output      logic       q_valid,
  output      beat_t      q_beat,
  input  wire logic       q_take
);
  beat_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  beat_t      b;
  logic       push;

  always_comb begin
    b.restart = (in_operation == OP_RESTART);
    b.data = in_data_byte;
    b.is_ctl = f_is_ctl(in_data_byte);
    b.is_token = (in_data_byte < 8'd127) && !f_is_ctl(in_data_byte)
                 && !f_is_tspecial(in_data_byte);
    b.is_dec = (in_data_byte >= "0") && (in_data_byte <= "9");
    b.is_hex = 1'b1;
    b.hex = 4'd0;
    if (b.is_dec) begin
      b.hex = 4'(in_data_byte - "0");
    end else if (in_data_byte >= "a" && in_data_byte <= "f") begin
      b.hex = 4'(in_data_byte - "a" + 8'd10);
    end else if (in_data_byte >= "A" && in_data_byte <= "F") begin
      b.hex = 4'(in_data_byte - "A" + 8'd10);
    end else begin
      b.is_hex = 1'b0;
    end
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != 2'd0);
  assign q_beat = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_take) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_take};
    end
  end
endmodule
`default_nettype wire

// ----- rtl/hrp_back.sv -----
// Back end: grammar state machine, URI decoder and registered result.
`default_nettype none
module hrp_back import hrp_pkg::*; #(
  parameter int VERSION_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  wire beat_t       q_beat,
  output      logic        q_take,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [1:0]  out_status,
  output      logic [2:0]  out_field_kind,
  output      logic [7:0]  out_field_byte,
  output      logic        out_byte_valid,
  output      logic        out_header_start,
  output      logic [15:0] out_version_major,
  output      logic [15:0] out_version_minor
);
  localparam int VW = VERSION_BITS + 4;
  localparam logic [VW-1:0] VMAX = VW'((64'd1 << VERSION_BITS) - 64'd1);

  state_t st_r, st_nxt;
  logic hdr_r, hdr_nxt, pnz_r, pnz_nxt, dot_r, dot_nxt, inq_r, inq_nxt;
  logic [1:0] pp_r, pp_nxt, sts_r, sts_nxt;
  logic [3:0] hn_r, hn_nxt;
  logic [VERSION_BITS-1:0] maj_r, maj_nxt, min_r, min_nxt;
  logic [2:0] kind;
  logic [7:0] byt, d;
  logic vld, hs, have, step;
  logic [VW-1:0] prod_maj, prod_min;
  logic [VERSION_BITS-1:0] sat_maj, sat_min;
  logic [7:0] c;

  assign c = q_beat.data;
  // Take a beat whenever the result register is empty or being drained.
  assign q_take = q_valid && (!out_valid || !out_stall);
  assign step = q_take;

  // Version accumulate: v*10 + digit, saturating.
  always_comb begin
    prod_maj = (VW'(maj_r) << 3) + (VW'(maj_r) << 1) + VW'(q_beat.hex);
    prod_min = (VW'(min_r) << 3) + (VW'(min_r) << 1) + VW'(q_beat.hex);
    sat_maj = (prod_maj > VMAX) ? VMAX[VERSION_BITS-1:0] : prod_maj[VERSION_BITS-1:0];
    sat_min = (prod_min > VMAX) ? VMAX[VERSION_BITS-1:0] : prod_min[VERSION_BITS-1:0];
  end

  always_comb begin
    st_nxt = st_r; hdr_nxt = hdr_r; pnz_nxt = pnz_r; dot_nxt = dot_r;
    inq_nxt = inq_r; pp_nxt = pp_r; sts_nxt = sts_r; hn_nxt = hn_r;
    maj_nxt = maj_r; min_nxt = min_r;
    kind = FK_NONE; byt = 8'd0; vld = 1'b0; hs = 1'b0; have = 1'b0; d = 8'd0;
    if (q_beat.restart) begin
      st_nxt = S_METHOD_START; hdr_nxt = 1'b0; pnz_nxt = 1'b0; dot_nxt = 1'b0;
      inq_nxt = 1'b0; pp_nxt = 2'd0; sts_nxt = ST_BUSY; hn_nxt = 4'd0;
      maj_nxt = '0; min_nxt = '0;
    end else if (sts_r == ST_BUSY) begin
      case (st_r)
        S_METHOD_START: begin
          if (!q_beat.is_token) sts_nxt = ST_SYNTAX;
          else begin st_nxt = S_METHOD; kind = FK_METHOD; byt = c; vld = 1'b1; end
        end
        S_METHOD: begin
          if (c == " ") begin
            st_nxt = S_URI; pp_nxt = 2'd0; hn_nxt = 4'd0;
            pnz_nxt = 1'b0; dot_nxt = 1'b0; inq_nxt = 1'b0;
          end else if (!q_beat.is_token) sts_nxt = ST_SYNTAX;
          else begin kind = FK_METHOD; byt = c; vld = 1'b1; end
        end
        S_URI: begin
          if (c == " ") begin
            if (pp_r != 2'd0 || !pnz_r) sts_nxt = ST_BAD_URI;
            else st_nxt = S_H;
          end else if (q_beat.is_ctl) sts_nxt = ST_SYNTAX;
          else if (pp_r == 2'd1) begin
            if (!q_beat.is_hex) sts_nxt = ST_BAD_URI;
            else begin hn_nxt = q_beat.hex; pp_nxt = 2'd2; end
          end else if (pp_r == 2'd2) begin
            if (!q_beat.is_hex) sts_nxt = ST_BAD_URI;
            else begin
              d = {hn_r, q_beat.hex}; pp_nxt = 2'd0; hn_nxt = 4'd0; have = 1'b1;
            end
          end else if (c == "%") pp_nxt = 2'd1;
          else begin d = (c == "+") ? 8'h20 : c; have = 1'b1; end
          if (have) begin
            if (inq_r) begin kind = FK_QUERY; byt = d; vld = 1'b1; end
            else if (d == "?") inq_nxt = 1'b1;
            else if (!pnz_r && d != "/") sts_nxt = ST_BAD_URI;
            else if (d == "." && dot_r) sts_nxt = ST_BAD_URI;
            else begin
              dot_nxt = (d == "."); pnz_nxt = 1'b1;
              kind = FK_PATH; byt = d; vld = 1'b1;
            end
          end
        end
        S_H:  if (c == "H") st_nxt = S_T1; else sts_nxt = ST_SYNTAX;
        S_T1: if (c == "T") st_nxt = S_T2; else sts_nxt = ST_SYNTAX;
        S_T2: if (c == "T") st_nxt = S_P; else sts_nxt = ST_SYNTAX;
        S_P:  if (c == "P") st_nxt = S_SLASH; else sts_nxt = ST_SYNTAX;
        S_SLASH: begin
          if (c == "/") begin maj_nxt = '0; min_nxt = '0; st_nxt = S_MAJ_START; end
          else sts_nxt = ST_SYNTAX;
        end
        S_MAJ_START: begin
          if (q_beat.is_dec) begin maj_nxt = sat_maj; st_nxt = S_MAJ; end
          else sts_nxt = ST_SYNTAX;
        end
        S_MAJ: begin
          if (c == ".") st_nxt = S_MIN_START;
          else if (q_beat.is_dec) maj_nxt = sat_maj;
          else sts_nxt = ST_SYNTAX;
        end
        S_MIN_START: begin
          if (c == 8'h0d) st_nxt = S_NL1;
          else if (q_beat.is_dec) min_nxt = sat_min;
          else sts_nxt = ST_SYNTAX;
        end
        S_NL1: if (c == 8'h0a) st_nxt = S_LINE_START; else sts_nxt = ST_SYNTAX;
        S_LINE_START: begin
          if (c == 8'h0d) st_nxt = S_NL3;
          else if (hdr_r && (c == " " || c == 8'h09)) st_nxt = S_LWS;
          else if (!q_beat.is_token) sts_nxt = ST_SYNTAX;
          else begin
            hdr_nxt = 1'b1; st_nxt = S_HNAME;
            kind = FK_HNAME; byt = c; vld = 1'b1; hs = 1'b1;
          end
        end
        S_LWS: begin
          if (c == 8'h0d) st_nxt = S_NL2;
          else if (c != " " && c != 8'h09) begin
            st_nxt = S_HVALUE; kind = FK_HVALUE; byt = c; vld = 1'b1;
          end
        end
        S_HNAME: begin
          if (c == ":") st_nxt = S_SP_BEFORE_VALUE;
          else if (!q_beat.is_token) sts_nxt = ST_SYNTAX;
          else begin kind = FK_HNAME; byt = c; vld = 1'b1; end
        end
        S_SP_BEFORE_VALUE: if (c == " ") st_nxt = S_HVALUE; else sts_nxt = ST_SYNTAX;
        S_HVALUE: begin
          if (c == 8'h0d) st_nxt = S_NL2;
          else if (q_beat.is_ctl) sts_nxt = ST_SYNTAX;
          else begin kind = FK_HVALUE; byt = c; vld = 1'b1; end
        end
        S_NL2: if (c == 8'h0a) st_nxt = S_LINE_START; else sts_nxt = ST_SYNTAX;
        S_NL3: sts_nxt = (c == 8'h0a) ? ST_DONE : ST_SYNTAX;
        default: sts_nxt = ST_SYNTAX;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_METHOD_START; hdr_r <= 1'b0; pnz_r <= 1'b0; dot_r <= 1'b0;
      inq_r <= 1'b0; pp_r <= 2'd0; sts_r <= ST_BUSY; hn_r <= 4'd0;
      maj_r <= '0; min_r <= '0; out_valid <= 1'b0;
    end else begin
      if (step) begin
        st_r <= st_nxt; hdr_r <= hdr_nxt; pnz_r <= pnz_nxt; dot_r <= dot_nxt;
        inq_r <= inq_nxt; pp_r <= pp_nxt; sts_r <= sts_nxt; hn_r <= hn_nxt;
        maj_r <= maj_nxt; min_r <= min_nxt;
      end
      if (step) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // Result payload; hold while stalled.
  always_ff @(posedge clk) begin
    if (step) begin
      out_status <= sts_nxt;
      out_field_kind <= kind;
      out_field_byte <= byt;
      out_byte_valid <= vld;
      out_header_start <= hs;
      out_version_major <= 16'(maj_nxt);
      out_version_minor <= 16'(min_nxt);
    end
  end
endmodule
`default_nettype wire

// ----- rtl/http_request_header_parser.sv -----
// Top level of the HTTP request line and header parser.
// Usage:
//  - Input channel: one beat per request byte (in_operation = 0) or a restart
//    (in_operation = 1), accepted when in_valid is high and in_stall is low.
//  - Output channel: exactly one result beat per input beat, in order, with
//    the sticky status, the tagged field byte and the versions so far.
//  - Path: an accepted beat is written to the front queue, then to the result
//    register once the back end takes it from the queue.
//  - Throughput: one beat per cycle while out_stall is low; the back end settles
//    one byte per cycle and the two-entry queue absorbs a stall.
//  - Output stall: the result register holds; the back end stops draining
//    the queue, and in_stall rises once both queue entries are full.
//  - Reset (rst_n low, synchronous): the queue empties, no result is valid
//    and the parser returns to the start of the method token.
//  - Restart beat: clears all parser state; the result reports all zeros.
//  - Once the status is nonzero it stays until a restart beat.
`default_nettype none
`include "http_request_header_parser_macros.svh"
module http_request_header_parser import hrp_pkg::*; #(
  parameter int VERSION_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic        in_operation,
  input  wire logic [7:0]  in_data_byte,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [1:0]  out_status,
  output      logic [2:0]  out_field_kind,
  output      logic [7:0]  out_field_byte,
  output      logic        out_byte_valid,
  output      logic        out_header_start,
  output      logic [15:0] out_version_major,
  output      logic [15:0] out_version_minor
);
  logic  q_valid, q_take;
  beat_t q_beat;

  // Classify and buffer incoming beats.
  hrp_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_operation, .in_data_byte,
    .q_valid, .q_beat, .q_take
  );

  // Advance the grammar and drive the result register.
  hrp_back #(.VERSION_BITS(VERSION_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_beat, .q_take, .out_valid, .out_stall,
    .out_status, .out_field_kind, .out_field_byte, .out_byte_valid,
    .out_header_start, .out_version_major, .out_version_minor
  );

  `HRP_ASSERT_IMP(a_take_needs_data, q_take, q_valid)
  `HRP_ASSERT_NEXT(a_take_fills_out, q_take, out_valid)
  `HRP_ASSERT_IMP(a_byte_has_kind, out_valid && out_byte_valid, out_field_kind != FK_NONE)
  `HRP_ASSERT_IMP(a_start_is_name, out_valid && out_header_start, out_field_kind == FK_HNAME)
endmodule
`default_nettype wire
